>>> hw/rtl/fsc_pkg.sv
// Shared constants and helpers for the frustum sphere culler.
// No dependencies.
package fsc_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PLANE_COUNT = 6;
	localparam int MAT_DEPTH = 16;
	localparam int PLANE_DEPTH = 24;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEST = 1'b1;

	// source row and sign per plane: right, left, down, up, far, near
	function automatic logic [1:0] plane_row(input logic [2:0] p);
		logic [1:0] r;
		case (p)
			3'd0, 3'd1: r = 2'd0;
			3'd2, 3'd3: r = 2'd1;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic plane_add(input logic [2:0] p);
		logic a;
		case (p)
			3'd1, 3'd2, 3'd5: a = 1'b1;
			default:          a = 1'b0;
		endcase
		return a;
	endfunction
endpackage

>>> hw/rtl/fsc_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module fsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/fsc_div.sv
// Iterative unit: restoring square root and unsigned divider, one bit a cycle.
// Depends on nothing but its parameter.
module fsc_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic           sqrt_mode,
	input  logic [2*W-1:0] num,
	input  logic [2*W-1:0] den,
	output logic           done,
	output logic [2*W-1:0] res
);
	localparam int NW = 2 * W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] rem_q, quo_q, num_q;
	logic [NW+1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, mode_q;
	logic [NW+1:0] trial, tsq;
	logic [NW+1:0] acc_n;
	logic [NW+1:0] tdiv;

	// sqrt: acc holds partial remainder; quo the root
	always_comb begin
		acc_n = {acc_q[NW-1:0], num_q[NW-1:NW-2]};
		tsq   = {quo_q, 2'b01};
		trial = acc_n - tsq;
		tdiv  = {acc_q[NW:0], num_q[NW-1]} - {2'b00, rem_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && (cnt_q == CW'(1));
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= sqrt_mode ? CW'(NW / 2) : CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			mode_q <= sqrt_mode;
			num_q  <= num;
			rem_q  <= den;
			quo_q  <= '0;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (mode_q) begin
				num_q <= num_q << 2;
				if (!trial[NW+1]) begin
					acc_q <= trial;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					acc_q <= acc_n;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end else begin
				num_q <= num_q << 1;
				if (!tdiv[NW+1]) begin
					acc_q <= tdiv;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[NW:0], num_q[NW-1]};
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
		end
	end

	assign res = quo_q;
endmodule

>>> hw/rtl/frustum_sphere_cull.sv
// Top level of the frustum sphere culler: sequencer, matrix and plane memories.
// Depends on fsc_pkg, fsc_ram and fsc_div.
//
// After reset busy stays high while both memories are swept to zero. A test
// request keeps busy high while it examines the planes in turn (each of the
// four plane coefficients takes a read, a multiply and an accumulate step)
// and stops at the first plane the sphere lies outside. visible comes with
// done for one cycle, the first cycle with busy low again. A load request
// first writes the column, then rebuilds all six planes through the shared
// bit-serial square root and divider unit: per plane the matrix reads, the
// squaring, the root (W iterations) and one division per coefficient (2W
// iterations); a plane with a zero-length normal skips the divisions. A load
// gives no result. The receiver cannot stall, so nothing waits on it.
module frustum_sphere_cull #(
	parameter int WORD_WIDTH = fsc_pkg::WORD_WIDTH,
	parameter int FRAC_BITS  = fsc_pkg::FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [1:0]                   column_index,
	input  logic signed [WORD_WIDTH-1:0] elem_row0,
	input  logic signed [WORD_WIDTH-1:0] elem_row1,
	input  logic signed [WORD_WIDTH-1:0] elem_row2,
	input  logic signed [WORD_WIDTH-1:0] elem_row3,
	input  logic signed [WORD_WIDTH-1:0] center_x,
	input  logic signed [WORD_WIDTH-1:0] center_y,
	input  logic signed [WORD_WIDTH-1:0] center_z,
	input  logic signed [WORD_WIDTH-1:0] sphere_radius,
	output logic                         done,
	output logic                         visible
);
	localparam int W  = WORD_WIDTH;
	localparam int NW = 2 * W;
	localparam int MA = $clog2(fsc_pkg::MAT_DEPTH);
	localparam int PA = $clog2(fsc_pkg::PLANE_DEPTH);
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [NW-1:0] QLIM = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LWR   = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_RD2   = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_SQW   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_DIVW  = 4'd7;
	localparam logic [3:0] ST_TRD   = 4'd8;
	localparam logic [3:0] ST_TMUL  = 4'd9;
	localparam logic [3:0] ST_TACC  = 4'd10;
	localparam logic [3:0] ST_WB    = 4'd11;

	logic [3:0]  st_q;
	logic [2:0]  plane_q;
	logic [1:0]  k_q;
	logic [1:0]  wr_q;
	logic        first_q;
	logic        vis_q;
	logic [1:0]  column_index_q;
	logic signed [W-1:0] elem_q [4];
	logic signed [W-1:0] cen_q [3];
	logic signed [W-1:0] rad_q;
	logic signed [W-1:0] r3_q, raw_q [4];
	logic [NW-1:0] sq_q, len_q;
	logic signed [NW+2:0] sum_q;
	logic signed [NW-1:0] prod_q;
	logic signed [W-1:0] p_rdata_q;
	logic          done_vis_q;

	// matrix RAM
	logic          m_we;
	logic [MA-1:0] m_waddr, m_raddr;
	logic [W-1:0]  m_wdata, m_rdata;
	// plane RAM
	logic          p_we;
	logic [PA-1:0] p_waddr, p_raddr;
	logic [W-1:0]  p_wdata, p_rdata;

	fsc_ram #(.WIDTH(W), .DEPTH(fsc_pkg::MAT_DEPTH)) u_mat (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata));
	fsc_ram #(.WIDTH(W), .DEPTH(fsc_pkg::PLANE_DEPTH)) u_pln (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	// reset leaves RAMs undefined: a sweep after reset zeroes them
	logic        clr_q;
	logic [PA-1:0] clr_cnt_q;

	logic          d_go, d_sqrt, d_done;
	logic [NW-1:0] d_num, d_den, d_res;

	fsc_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(d_go), .sqrt_mode(d_sqrt),
		.num(d_num), .den(d_den), .done(d_done), .res(d_res));

	// raw plane term: r3 +/- rs, saturated
	logic signed [W:0]   raw_full;
	logic signed [W-1:0] raw_sat;
	always_comb begin
		if (fsc_pkg::plane_add(plane_q))
			raw_full = {r3_q[W-1], r3_q} + {m_rdata[W-1], m_rdata};
		else
			raw_full = {r3_q[W-1], r3_q} - {m_rdata[W-1], m_rdata};
		if (raw_full > $signed({2'b00, SMAX[W-2:0]}))
			raw_sat = SMAX;
		else if (raw_full < $signed({2'b11, SMIN[W-2:0]}))
			raw_sat = SMIN;
		else
			raw_sat = raw_full[W-1:0];
	end

	logic [W-1:0]  mag_k;
	logic [NW-1:0] sq_k;
	always_comb begin
		mag_k = raw_q[k_q][W-1] ? W'(-raw_q[k_q]) : raw_q[k_q];
		sq_k  = NW'(mag_k) * NW'(mag_k);
	end

	// scaled coefficient from quotient, saturate and sign
	logic [W-1:0]  qsat;
	logic [W-1:0]  scaled;
	always_comb begin
		if (d_res > QLIM)
			qsat = SMIN;
		else
			qsat = d_res[W-1:0];
		if (raw_q[k_q][W-1])
			scaled = W'(-qsat);
		else if (qsat == SMIN)
			scaled = SMAX;
		else
			scaled = qsat;
	end

	logic signed [W-1:0] cen_k;
	logic signed [NW-1:0] prod_sh;
	assign cen_k = cen_q[k_q];
	assign prod_sh = prod_q >>> FRAC_BITS;

	logic signed [NW+2:0] sum_next;
	logic                 outside;
	logic                 test_end;
	assign sum_next = sum_q + (NW+3)'(prod_sh);
	assign outside  = (sum_q + (NW+3)'(p_rdata_q) + (NW+3)'(rad_q)) <= 0;
	assign test_end = (st_q == ST_TACC) && (k_q == 2'd3)
		&& (outside || plane_q == 3'(fsc_pkg::PLANE_COUNT - 1));

	logic [2:0] col_rd;
	always_comb begin
		col_rd = {1'b0, k_q};
		m_raddr = MA'(col_rd) * MA'(4) + (wr_q[0] ? MA'(3)
			: MA'(fsc_pkg::plane_row(plane_q)));
		p_raddr = PA'(plane_q) * PA'(4) + PA'(k_q);
	end

	always_comb begin
		m_we    = 1'b0;
		m_waddr = MA'({column_index, 2'b00});
		m_wdata = '0;
		p_we    = 1'b0;
		p_waddr = PA'(plane_q) * PA'(4) + PA'(k_q);
		p_wdata = raw_q[k_q];
		d_go    = 1'b0;
		d_sqrt  = 1'b0;
		d_num   = sq_q;
		d_den   = len_q;
		if (clr_q) begin
			m_we    = 1'b1;
			m_waddr = clr_cnt_q[MA-1:0];
			p_we    = 1'b1;
			p_waddr = clr_cnt_q;
			p_wdata = '0;
		end else begin
			case (st_q)
				ST_LWR: begin
					m_we    = 1'b1;
					m_waddr = MA'({column_index_q, wr_q});
					m_wdata = elem_q[wr_q];
				end
				ST_SQ: begin
					// root starts once all three squares are summed
					d_go   = (k_q == 2'd3);
					d_sqrt = 1'b1;
				end
				ST_DIV: begin
					d_go  = 1'b1;
					d_num = NW'(mag_k) << FRAC_BITS;
				end
				ST_WB: begin
					p_we    = 1'b1;
					p_wdata = (len_q == '0) ? raw_q[k_q] : scaled;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			done      <= 1'b0;
			plane_q   <= '0;
			k_q       <= '0;
			wr_q      <= '0;
			first_q   <= 1'b0;
			r3_q      <= '0;
			raw_q     <= '{default: '0};
			sq_q      <= '0;
			len_q     <= '0;
		end else begin
			done <= test_end;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == PA'(fsc_pkg::PLANE_DEPTH - 1))
					clr_q <= 1'b0;
			end else begin
				case (st_q)
					ST_IDLE: if (start) begin
						k_q <= '0; plane_q <= '0; wr_q <= '0;
						st_q <= (mode == fsc_pkg::MODE_LOAD) ? ST_LWR : ST_TRD;
					end
					ST_LWR: begin
						if (wr_q == 2'd3) begin
							wr_q <= 2'd1; k_q <= '0; st_q <= ST_RD;
						end else
							wr_q <= wr_q + 1'b1;
					end
					// read r3 (wr_q[0]=1) then the source row of column k
					ST_RD: begin
						first_q <= wr_q[0];
						wr_q    <= {1'b0, ~wr_q[0]};
						st_q    <= ST_RD2;
					end
					ST_RD2: begin
						if (first_q) begin
							r3_q <= m_rdata;
							st_q <= ST_RD;
						end else begin
							raw_q[k_q] <= raw_sat;
							wr_q <= 2'd1;
							// wraps to zero after the last column
							k_q  <= k_q + 1'b1;
							if (k_q == 2'd3) begin
								sq_q <= '0; st_q <= ST_SQ;
							end else st_q <= ST_RD;
						end
					end
					ST_SQ: begin
						// accumulate squares over k = 0..2, then root
						if (k_q != 2'd3) begin
							sq_q <= sq_q + sq_k;
							k_q  <= k_q + 1'b1;
						end else st_q <= ST_SQW;
					end
					ST_SQW: if (d_done) begin
						len_q <= d_res; k_q <= '0;
						st_q  <= (d_res == '0) ? ST_WB : ST_DIV;
					end
					ST_DIV: st_q <= ST_DIVW;
					ST_DIVW: if (d_done) st_q <= ST_WB;
					ST_WB: begin
						k_q <= k_q + 1'b1;
						if (k_q != 2'd3)
							st_q <= (len_q == '0) ? ST_WB : ST_DIV;
						else if (plane_q == 3'(fsc_pkg::PLANE_COUNT - 1))
							st_q <= ST_IDLE;
						else begin
							plane_q <= plane_q + 1'b1; wr_q <= 2'd1;
							st_q <= ST_RD;
						end
					end
					ST_TRD: st_q <= ST_TMUL;
					ST_TMUL: st_q <= ST_TACC;
					ST_TACC: begin
						k_q <= k_q + 1'b1;
						if (k_q != 2'd3)
							st_q <= ST_TRD;
						else if (test_end)
							st_q <= ST_IDLE;
						else begin
							plane_q <= plane_q + 1'b1; st_q <= ST_TRD;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			column_index_q <= column_index;
			elem_q[0] <= elem_row0; elem_q[1] <= elem_row1;
			elem_q[2] <= elem_row2; elem_q[3] <= elem_row3;
			cen_q[0] <= center_x; cen_q[1] <= center_y; cen_q[2] <= center_z;
			rad_q <= sphere_radius;
			sum_q <= '0;
			vis_q <= 1'b1;
		end
		if (st_q == ST_TMUL) begin
			p_rdata_q <= p_rdata;
			if (k_q != 2'd3)
				prod_q <= NW'(cen_k) * NW'($signed(p_rdata));
			else
				prod_q <= '0;
		end
		if (st_q == ST_TACC) begin
			if (k_q != 2'd3)
				sum_q <= sum_next;
			else begin
				sum_q <= '0;
				if (outside)
					vis_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (test_end)
			done_vis_q <= vis_q && !outside;
	end

	assign visible = done_vis_q;

	assign busy = clr_q || (st_q != ST_IDLE);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_IDLE)
		else $error("done outside idle");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request not taken");
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> st_q == ST_IDLE)
		else $error("work during clear");
`endif
endmodule

>>> sim/tb_frustum_sphere_cull.sv
// Testbench for frustum_sphere_cull: matrix column loads and sphere test requests,
// checked against a behavioral culler held in a small scoreboard class.
// Depends on fsc_pkg and the frustum_sphere_cull RTL.
module tb_frustum_sphere_cull;
	localparam longint LIMIT_CYCLES = 4000000;
	localparam int     ONE = 1 << fsc_pkg::FRAC_BITS;

	class cull_scoreboard;
		longint        matrix[16];
		longint        plane[24];
		bit            visible_q[$];
		int            mismatches;
		int            row_of[6] = '{0, 0, 1, 1, 2, 2};
		bit            adds[6]   = '{0, 1, 1, 0, 0, 1};

		function new();
			foreach (matrix[i]) matrix[i] = 0;
			foreach (plane[i]) plane[i] = 0;
			mismatches = 0;
		endfunction

		function longint sat_word(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void rebuild();
			longint raw[4];
			longint unsigned sq, len, m, q;
			for (int p = 0; p < 6; p++) begin
				for (int k = 0; k < 4; k++) begin
					if (adds[p]) raw[k] = sat_word(matrix[k*4+3] + matrix[k*4+row_of[p]]);
					else raw[k] = sat_word(matrix[k*4+3] - matrix[k*4+row_of[p]]);
				end
				sq = 0;
				for (int k = 0; k < 3; k++) begin
					m = raw[k] < 0 ? -raw[k] : raw[k];
					sq = sq + m * m;
				end
				len = root(sq);
				for (int k = 0; k < 4; k++) begin
					if (len == 0) begin
						plane[p*4+k] = raw[k];
					end else begin
						m = raw[k] < 0 ? -raw[k] : raw[k];
						q = (m << fsc_pkg::FRAC_BITS) / len;
						if (q > (64'd1 << 31)) q = 64'd1 << 31;
						plane[p*4+k] = sat_word(raw[k] < 0 ? -longint'(q) : longint'(q));
					end
				end
			end
		endfunction

		// accepted request: loads update the planes, tests queue a visibility bit
		function void note(logic md, logic [1:0] col, logic signed [31:0] e[4],
			logic signed [31:0] c[4]);
			longint s;
			bit vis;
			if (md == fsc_pkg::MODE_LOAD) begin
				for (int r = 0; r < 4; r++) matrix[col*4+r] = longint'(e[r]);
				rebuild();
				return;
			end
			vis = 1;
			for (int p = 0; p < 6 && vis; p++) begin
				s = ((longint'(c[0]) * plane[p*4]) >>> fsc_pkg::FRAC_BITS)
				  + ((longint'(c[1]) * plane[p*4+1]) >>> fsc_pkg::FRAC_BITS)
				  + ((longint'(c[2]) * plane[p*4+2]) >>> fsc_pkg::FRAC_BITS)
				  + plane[p*4+3] + longint'(c[3]);
				if (s <= 0) vis = 0;
			end
			visible_q.push_back(vis);
		endfunction

		function void check(logic got);
			bit want;
			if (visible_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result visible=%0b", got);
				return;
			end
			want = visible_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("visible mismatch: expected %0b got %0b", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0, mode = 0;
	logic [1:0] column_index = 0;
	logic signed [31:0] elem_row0 = 0, elem_row1 = 0, elem_row2 = 0, elem_row3 = 0;
	logic signed [31:0] center_x = 0, center_y = 0, center_z = 0, sphere_radius = 0;
	logic busy, done, visible;
	longint cycles = 0;
	int sent = 0;
	bit quiet = 0;
	bit drained = 0;
	cull_scoreboard sb = new();

	frustum_sphere_cull dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.column_index(column_index), .elem_row0(elem_row0), .elem_row1(elem_row1),
		.elem_row2(elem_row2), .elem_row3(elem_row3), .center_x(center_x),
		.center_y(center_y), .center_z(center_z), .sphere_radius(sphere_radius),
		.done(done), .visible(visible)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check(visible);
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(logic md, logic [1:0] col, logic signed [31:0] e[4],
		logic signed [31:0] c[4]);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		mode = md;
		column_index = col;
		{elem_row0, elem_row1, elem_row2, elem_row3} = {e[0], e[1], e[2], e[3]};
		{center_x, center_y, center_z, sphere_radius} = {c[0], c[1], c[2], c[3]};
		start = 1;
		while (busy) @(negedge clk);
		sb.note(md, col, e, c);
		sent++;
		@(negedge clk);
		start = 0;
	endtask

	function automatic logic signed [31:0] rand_word(int spread);
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 2 * spread)) - spread;
		endcase
	endfunction

	task automatic load_col(logic [1:0] col, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c, logic signed [31:0] d);
		logic signed [31:0] e[4];
		logic signed [31:0] z[4];
		e = '{a, b, c, d};
		z = '{$urandom, $urandom, $urandom, $urandom};
		send_request(fsc_pkg::MODE_LOAD, col, e, z);
	endtask

	task automatic test_sphere(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z, logic signed [31:0] r);
		logic signed [31:0] e[4];
		logic signed [31:0] c[4];
		e = '{$urandom, $urandom, $urandom, $urandom};
		c = '{x, y, z, r};
		send_request(fsc_pkg::MODE_TEST, 2'($urandom), e, c);
	endtask

	initial begin
		int n, spread;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset planes are all zero: only a positive radius is visible
		test_sphere(0, 0, 0, 1);
		test_sphere(0, 0, 0, 0);
		test_sphere(32'sh7fffffff, 32'sh80000000, 5, -1);
		test_sphere(32'sh80000000, 32'sh7fffffff, -7, 32'sh7fffffff);
		// identity matrix: unit cube frustum
		load_col(0, ONE, 0, 0, 0);
		load_col(1, 0, ONE, 0, 0);
		load_col(2, 0, 0, ONE, 0);
		load_col(3, 0, 0, 0, ONE);
		test_sphere(0, 0, 0, 0);
		test_sphere(2 * ONE, 0, 0, ONE / 2);
		test_sphere(2 * ONE, 0, 0, ONE);
		test_sphere(0, -3 * ONE, 0, 2 * ONE);
		test_sphere(0, 0, ONE + 1, 0);
		test_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		// saturating row sums and zero-length normals
		load_col(0, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff);
		load_col(1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		load_col(2, 0, 0, 0, 0);
		test_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		test_sphere(ONE, -ONE, 0, 32'sh80000000);
		load_col(0, 0, 0, 0, 0);
		load_col(1, 0, 0, 0, 0);
		load_col(3, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		test_sphere(3, 4, 5, 6);
		test_sphere(-1, -1, -1, -1);

		while (sent < 900) begin
			if (sent > 800) quiet = 1;
			if (sent > 400 && !drained) begin
				drained = 1;
				start = 0;
				while (sb.visible_q.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 4) != 0) begin
				// plausible projection-view matrix then a burst of nearby spheres
				spread = $urandom_range(0, 1) ? 4 * ONE : 64 * ONE;
				for (int k = 0; k < 4; k++)
					if ($urandom_range(0, 5) != 0)
						load_col(2'(k), $signed($urandom_range(0, 2*spread)) - spread,
							$signed($urandom_range(0, 2*spread)) - spread,
							$signed($urandom_range(0, 2*spread)) - spread,
							$signed($urandom_range(0, 2*spread)) - spread);
				n = $urandom_range(10, 30);
				repeat (n) test_sphere(rand_word(8 * ONE), rand_word(8 * ONE),
					rand_word(8 * ONE), rand_word(4 * ONE));
			end else begin
				load_col(2'($urandom), rand_word(ONE), rand_word(ONE), $urandom,
					rand_word(ONE));
				repeat ($urandom_range(1, 8)) test_sphere($urandom, $urandom, $urandom,
					$urandom);
			end
		end

		start = 0;
		while (sb.visible_q.size() != 0) @(negedge clk);
		repeat (2500) @(negedge clk);
		if (sb.mismatches == 0 && sb.visible_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> files.f
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_ram.sv
hw/rtl/fsc_div.sv
hw/rtl/frustum_sphere_cull.sv
sim/tb_frustum_sphere_cull.sv
